/* rtl/gtaa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtaa_pkg
// Shared widths, field layout, action codes and types of the greedy
// task-to-agent assignment core.
// ----------------------------------------------------------------------------
package gtaa_pkg;

  // default sizes, handed to the top-level parameters
  localparam int MAX_AGENTS_DEF = 16;
  localparam int LOC_BITS_DEF   = 8;
  localparam int DIST_BITS_DEF  = 16;
  localparam int TIME_BITS_DEF  = 32;

  // fixed field widths of the stream items
  localparam int ACTION_W   = 2;
  localparam int LOC_W      = 8;
  localparam int DIST_W     = 16;
  localparam int AGENT_W    = 4;
  localparam int READY_W    = 32;
  localparam int COUNT_W    = 5;

  // input tdata layout, lowest bit first
  localparam int IN_FROM_LSB   = 0;
  localparam int IN_TO_LSB     = IN_FROM_LSB + LOC_W;
  localparam int IN_DVAL_LSB   = IN_TO_LSB + LOC_W;
  localparam int IN_AIDX_LSB   = IN_DVAL_LSB + DIST_W;
  localparam int IN_ALOC_LSB   = IN_AIDX_LSB + AGENT_W;
  localparam int IN_ARDY_LSB   = IN_ALOC_LSB + LOC_W;
  localparam int IN_PICK_LSB   = IN_ARDY_LSB + READY_W;
  localparam int IN_GOAL_LSB   = IN_PICK_LSB + LOC_W;
  localparam int IN_USED_W     = IN_GOAL_LSB + LOC_W;
  localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout, lowest bit first
  localparam int OUT_AGENT_LSB = 0;
  localparam int OUT_FIN_LSB   = OUT_AGENT_LSB + AGENT_W;
  localparam int OUT_SPAN_LSB  = OUT_FIN_LSB + READY_W;
  localparam int OUT_USED_W    = OUT_SPAN_LSB + READY_W;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_DIST    = 2'd0,
    ACT_START   = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_ASSIGN  = 2'd3
  } gtaa_action_t;

  // status of the shared unit's comparison
  typedef struct packed {
    logic less;
    logic greater;
  } gtaa_cmp_t;

endpackage

/* rtl/gtaa_dist_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtaa_dist_ram
// Location-to-location distance table, one write and one registered read.
// ----------------------------------------------------------------------------
module gtaa_dist_ram #(
  parameter int LOC_BITS  = gtaa_pkg::LOC_BITS_DEF,
  parameter int DIST_BITS = gtaa_pkg::DIST_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [2*LOC_BITS-1:0] wr_addr,
  input  logic [DIST_BITS-1:0]  wr_data,
  input  logic                  rd_en,
  input  logic [2*LOC_BITS-1:0] rd_addr,
  output logic [DIST_BITS-1:0]  rd_data_r
);

  localparam int DEPTH = 1 << (2 * LOC_BITS);

  logic [DIST_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* rtl/gtaa_sat_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtaa_sat_alu
// Shared saturating time-plus-distance adder with a compare on the sum.
// ----------------------------------------------------------------------------
module gtaa_sat_alu #(
  parameter int DIST_BITS = gtaa_pkg::DIST_BITS_DEF,
  parameter int TIME_BITS = gtaa_pkg::TIME_BITS_DEF
) (
  input  logic [TIME_BITS-1:0] op_a,
  input  logic [DIST_BITS-1:0] op_b,
  input  logic [TIME_BITS-1:0] op_cmp,
  output logic [TIME_BITS-1:0] sum,
  output gtaa_pkg::gtaa_cmp_t  cmp
);

  localparam int SW = ((TIME_BITS > DIST_BITS) ? TIME_BITS : DIST_BITS) + 1;

  logic [SW-1:0] sum_w;
  logic          sat;

  assign sum_w = SW'(op_a) + SW'(op_b);
  // clamp at the top of the time range
  assign sat   = sum_w > SW'({TIME_BITS{1'b1}});
  assign sum   = sat ? {TIME_BITS{1'b1}} : TIME_BITS'(sum_w);

  assign cmp.less    = sum < op_cmp;
  assign cmp.greater = sum > op_cmp;

endmodule

/* rtl/greedy_task_agent_assignment_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_task_agent_assignment_core
// Greedy list scheduling: each task goes to the agent in use that reaches
// its pickup first; reports the agent, its new ready time and the makespan.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_*    | in  | tuser: action; tdata: distance entry, agent start, task
//  out_*   | out | tdata: chosen_agent, ready_time, makespan
//  cfg_*   | in  | cfg_data: agent_count, written in one transfer
//
//  assign makes one distance-table read per agent in use, then one pass
//  of the shared adder per agent for the makespan; distance and start
//  writes make only the makespan pass, restart copies all starts first.
//  reset clears the agent state and sets agent_count to one; the distance
//  table is not cleared. a waiting result in the output register holds the
//  next result back until it is taken.
// ----------------------------------------------------------------------------
module greedy_task_agent_assignment_core #(
  parameter int MAX_AGENTS = gtaa_pkg::MAX_AGENTS_DEF,
  parameter int LOC_BITS   = gtaa_pkg::LOC_BITS_DEF,
  parameter int DIST_BITS  = gtaa_pkg::DIST_BITS_DEF,
  parameter int TIME_BITS  = gtaa_pkg::TIME_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // action
  input  logic [gtaa_pkg::ACTION_W-1:0]      in_tuser,
  // dist_from, dist_to, dist_value, agent_index, agent_loc, agent_ready,
  // task_start_loc, task_goal_loc, zero pad
  input  logic [gtaa_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // chosen_agent, ready_time, makespan, zero pad
  output logic [gtaa_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [gtaa_pkg::COUNT_W-1:0]       cfg_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready
);

  localparam int AG_BITS  = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int CNT_BITS = $clog2(MAX_AGENTS + 1);
  localparam logic [63:0] TIME_MAX64 = 64'({TIME_BITS{1'b1}});

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_COPY = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_FRD  = 7'b0001000,
    S_FIN  = 7'b0010000,
    S_SPAN = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  // input fields
  gtaa_pkg::gtaa_action_t         in_action;
  logic [gtaa_pkg::LOC_W-1:0]     f_from, f_to, f_aloc, f_pick, f_goal;
  logic [gtaa_pkg::DIST_W-1:0]    f_dval;
  logic [gtaa_pkg::AGENT_W-1:0]   f_aidx;
  logic [gtaa_pkg::READY_W-1:0]   f_ardy;

  assign in_action = gtaa_pkg::gtaa_action_t'(in_tuser);
  assign f_from = in_tdata[gtaa_pkg::IN_FROM_LSB +: gtaa_pkg::LOC_W];
  assign f_to   = in_tdata[gtaa_pkg::IN_TO_LSB   +: gtaa_pkg::LOC_W];
  assign f_dval = in_tdata[gtaa_pkg::IN_DVAL_LSB +: gtaa_pkg::DIST_W];
  assign f_aidx = in_tdata[gtaa_pkg::IN_AIDX_LSB +: gtaa_pkg::AGENT_W];
  assign f_aloc = in_tdata[gtaa_pkg::IN_ALOC_LSB +: gtaa_pkg::LOC_W];
  assign f_ardy = in_tdata[gtaa_pkg::IN_ARDY_LSB +: gtaa_pkg::READY_W];
  assign f_pick = in_tdata[gtaa_pkg::IN_PICK_LSB +: gtaa_pkg::LOC_W];
  assign f_goal = in_tdata[gtaa_pkg::IN_GOAL_LSB +: gtaa_pkg::LOC_W];

  // state
  state_t                  state_r, state_nxt;
  logic [CNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic [AG_BITS-1:0]      cnt_idx;
  logic                    pend_r, pend_nxt;
  logic [AG_BITS-1:0]      pidx_r, pidx_nxt;
  logic [AG_BITS-1:0]      best_r, best_nxt;
  logic [TIME_BITS-1:0]    best_t_r, best_t_nxt;
  logic [TIME_BITS-1:0]    rdy_pipe_r, rdy_pipe_nxt;
  logic [TIME_BITS-1:0]    finish_r, finish_nxt;
  logic [TIME_BITS-1:0]    span_r, span_nxt;
  gtaa_pkg::gtaa_action_t  act_r, act_nxt;
  logic [LOC_BITS-1:0]     pick_r, pick_nxt;
  logic [LOC_BITS-1:0]     goal_r, goal_nxt;
  logic [gtaa_pkg::COUNT_W-1:0] agent_count_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [gtaa_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [LOC_BITS-1:0]     start_loc_r   [MAX_AGENTS];
  logic [TIME_BITS-1:0]    start_ready_r [MAX_AGENTS];
  logic [LOC_BITS-1:0]     work_loc_r    [MAX_AGENTS];
  logic [TIME_BITS-1:0]    work_ready_r  [MAX_AGENTS];

  logic [CNT_BITS-1:0]     n_cnt;
  logic                    accept, out_load;
  logic                    start_wr;
  logic [TIME_BITS-1:0]    ready_sat;

  // distance table ports
  logic                    ram_we, ram_re;
  logic [2*LOC_BITS-1:0]   ram_waddr, ram_raddr;
  logic [DIST_BITS-1:0]    ram_wdata, ram_rdata;

  // shared unit ports
  logic [TIME_BITS-1:0]    alu_a, alu_cmp, alu_sum;
  logic [DIST_BITS-1:0]    alu_b;
  gtaa_pkg::gtaa_cmp_t     alu_st;

  assign cnt_idx   = cnt_r[AG_BITS-1:0];
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    if (agent_count_r == '0) begin
      n_cnt = CNT_BITS'(1);
    end else if (32'(agent_count_r) > MAX_AGENTS) begin
      n_cnt = CNT_BITS'(MAX_AGENTS);
    end else begin
      n_cnt = CNT_BITS'(agent_count_r);
    end
  end

  assign ready_sat = (64'(f_ardy) > TIME_MAX64) ? {TIME_BITS{1'b1}} : TIME_BITS'(f_ardy);
  assign start_wr  = accept && (in_action == gtaa_pkg::ACT_START) &&
                     (32'(f_aidx) < MAX_AGENTS);

  // distance table access
  assign ram_we    = accept && (in_action == gtaa_pkg::ACT_DIST);
  assign ram_waddr = {LOC_BITS'(f_from), LOC_BITS'(f_to)};
  assign ram_wdata = DIST_BITS'(f_dval);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {work_loc_r[cnt_idx], pick_r};
    case (state_r)
      S_SCAN: begin
        ram_re = (cnt_r != n_cnt);
      end
      S_FRD: begin
        ram_re    = 1'b1;
        ram_raddr = {pick_r, goal_r};
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  gtaa_dist_ram #(
    .LOC_BITS  (LOC_BITS),
    .DIST_BITS (DIST_BITS)
  ) u_dist_ram (
    .clk       (clk),
    .wr_en     (ram_we),
    .wr_addr   (ram_waddr),
    .wr_data   (ram_wdata),
    .rd_en     (ram_re),
    .rd_addr   (ram_raddr),
    .rd_data_r (ram_rdata)
  );

  // operand selection for the shared adder/compare
  always_comb begin
    alu_a   = work_ready_r[cnt_idx];
    alu_b   = '0;
    alu_cmp = span_r;
    case (state_r)
      S_SCAN: begin
        alu_a   = rdy_pipe_r;
        alu_b   = ram_rdata;
        alu_cmp = best_t_r;
      end
      S_FIN: begin
        alu_a = best_t_r;
        alu_b = ram_rdata;
      end
      default: begin
        alu_a = work_ready_r[cnt_idx];
      end
    endcase
  end

  gtaa_sat_alu #(
    .DIST_BITS (DIST_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .op_a   (alu_a),
    .op_b   (alu_b),
    .op_cmp (alu_cmp),
    .sum    (alu_sum),
    .cmp    (alu_st)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = 1'b0;
    pidx_nxt     = pidx_r;
    best_nxt     = best_r;
    best_t_nxt   = best_t_r;
    rdy_pipe_nxt = rdy_pipe_r;
    finish_nxt   = finish_r;
    span_nxt     = span_r;
    act_nxt      = act_r;
    pick_nxt     = pick_r;
    goal_nxt     = goal_r;
    out_load     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt  = in_action;
          pick_nxt = LOC_BITS'(f_pick);
          goal_nxt = LOC_BITS'(f_goal);
          cnt_nxt  = '0;
          span_nxt = '0;
          case (in_action)
            gtaa_pkg::ACT_RESTART: state_nxt = S_COPY;
            gtaa_pkg::ACT_ASSIGN:  state_nxt = S_SCAN;
            default:               state_nxt = S_SPAN;
          endcase
        end
      end
      S_COPY: begin
        if (cnt_r == CNT_BITS'(MAX_AGENTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SPAN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCAN: begin
        // issue read for agent cnt, evaluate the one read last cycle
        if (pend_r && (pidx_r == '0 || alu_st.less)) begin
          best_nxt   = pidx_r;
          best_t_nxt = alu_sum;
        end
        if (cnt_r == n_cnt) begin
          state_nxt = S_FRD;
        end else begin
          pend_nxt     = 1'b1;
          pidx_nxt     = cnt_idx;
          rdy_pipe_nxt = work_ready_r[cnt_idx];
          cnt_nxt      = cnt_r + 1'b1;
        end
      end
      S_FRD: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        finish_nxt = alu_sum;
        cnt_nxt    = '0;
        state_nxt  = S_SPAN;
      end
      S_SPAN: begin
        if (alu_st.greater) begin
          span_nxt = alu_sum;
        end
        if (cnt_r == n_cnt - 1'b1) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (out_load) begin
      out_data_nxt = '0;
      out_data_nxt[gtaa_pkg::OUT_SPAN_LSB +: gtaa_pkg::READY_W] =
        gtaa_pkg::READY_W'(span_r);
      if (act_r == gtaa_pkg::ACT_ASSIGN) begin
        out_data_nxt[gtaa_pkg::OUT_AGENT_LSB +: gtaa_pkg::AGENT_W] =
          gtaa_pkg::AGENT_W'(best_r);
        out_data_nxt[gtaa_pkg::OUT_FIN_LSB +: gtaa_pkg::READY_W] =
          gtaa_pkg::READY_W'(finish_r);
      end
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      agent_count_r <= gtaa_pkg::COUNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        agent_count_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    best_r     <= best_nxt;
    best_t_r   <= best_t_nxt;
    rdy_pipe_r <= rdy_pipe_nxt;
    finish_r   <= finish_nxt;
    span_r     <= span_nxt;
    act_r      <= act_nxt;
    pick_r     <= pick_nxt;
    goal_r     <= goal_nxt;
    out_data_r <= out_data_nxt;
  end

  // agent state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_AGENTS; i++) begin
        start_loc_r[i]   <= '0;
        start_ready_r[i] <= '0;
        work_loc_r[i]    <= '0;
        work_ready_r[i]  <= '0;
      end
    end else begin
      if (start_wr) begin
        start_loc_r[AG_BITS'(f_aidx)]   <= LOC_BITS'(f_aloc);
        start_ready_r[AG_BITS'(f_aidx)] <= ready_sat;
      end
      if (state_r == S_COPY) begin
        work_loc_r[cnt_idx]   <= start_loc_r[cnt_idx];
        work_ready_r[cnt_idx] <= start_ready_r[cnt_idx];
      end
      if (state_r == S_FIN) begin
        work_loc_r[best_r]   <= goal_r;
        work_ready_r[best_r] <= alu_sum;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in progress");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= n_cnt))
    else $error("agent scan ran past the agents in use");

  a_ram_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("distance table written and read in the same cycle");

  a_fin_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (work_ready_r[best_r] == finish_r))
    else $error("chosen agent ready time differs from the finish time");
`endif

endmodule

/* tb/greedy_task_agent_assignment_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_task_agent_assignment_core_tb
// Drives distance loads, agent start writes, restarts and task assignments
// through the input stream and checks every result against an in-bench
// scheduler that tracks the distance table and agent state. Directed tests
// cover the extremes, saturation and agent count limits; random phases run
// full schedules with noise, and idle gaps on both stream sides.
// ----------------------------------------------------------------------------
module greedy_task_agent_assignment_core_tb;
  import gtaa_pkg::*;

  localparam int NUM_AGENTS   = MAX_AGENTS_DEF;
  localparam int NUM_SITES    = 8;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 600000;
  // longest item is a task assignment at full agent count, plus margin
  localparam int DRAIN_CYCLES = 2 * MAX_AGENTS_DEF + 20;
  localparam int PRINT_CAP    = 50;

  typedef logic [IN_TDATA_W-1:0] item_data_t;

  typedef struct packed {
    logic [AGENT_W-1:0] agent;
    logic [READY_W-1:0] finish;
    logic [READY_W-1:0] span;
  } sched_result_t;

  logic                   clk;
  logic                   rst_n;
  logic [ACTION_W-1:0]    in_tuser;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [COUNT_W-1:0]     cfg_data;
  logic                   cfg_valid;
  logic                   cfg_ready;

  greedy_task_agent_assignment_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  // scheduler state mirrored in the bench
  logic [DIST_W-1:0]  dist_mem [0:(1 << (2 * LOC_W)) - 1];
  logic [LOC_W-1:0]   start_loc [NUM_AGENTS];
  logic [READY_W-1:0] start_rdy [NUM_AGENTS];
  logic [LOC_W-1:0]   work_loc [NUM_AGENTS];
  logic [READY_W-1:0] work_rdy [NUM_AGENTS];
  logic [COUNT_W-1:0] agent_count_reg;

  sched_result_t pending_results [$];
  // locations with a fully written distance matrix between them
  logic [LOC_W-1:0] sites [NUM_SITES];

  int  mismatches;
  int  items_sent;
  int  cycle_count;
  bit  calm;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [READY_W-1:0] sat_sum(logic [READY_W-1:0] a,
                                                 logic [READY_W-1:0] b);
    logic [READY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[READY_W] ? '1 : s[READY_W-1:0];
  endfunction

  function automatic int agents_active();
    if (agent_count_reg == 0) return 1;
    if (agent_count_reg > NUM_AGENTS) return NUM_AGENTS;
    return int'(agent_count_reg);
  endfunction

  function automatic sched_result_t schedule_step(gtaa_action_t act, item_data_t d);
    sched_result_t      res;
    int                 n;
    int                 best;
    int                 idx;
    logic [READY_W-1:0] best_t;
    logic [READY_W-1:0] t;
    logic [LOC_W-1:0]   pick;
    logic [LOC_W-1:0]   goal;
    res = '0;
    n = agents_active();
    case (act)
      ACT_DIST: begin
        dist_mem[{d[IN_FROM_LSB +: LOC_W], d[IN_TO_LSB +: LOC_W]}] = d[IN_DVAL_LSB +: DIST_W];
      end
      ACT_START: begin
        idx = int'(d[IN_AIDX_LSB +: AGENT_W]);
        start_loc[idx] = d[IN_ALOC_LSB +: LOC_W];
        start_rdy[idx] = d[IN_ARDY_LSB +: READY_W];
      end
      ACT_RESTART: begin
        for (int i = 0; i < NUM_AGENTS; i++) begin
          work_loc[i] = start_loc[i];
          work_rdy[i] = start_rdy[i];
        end
      end
      default: begin
        pick = d[IN_PICK_LSB +: LOC_W];
        goal = d[IN_GOAL_LSB +: LOC_W];
        best = 0;
        best_t = '0;
        for (int i = 0; i < n; i++) begin
          t = sat_sum(work_rdy[i], READY_W'(dist_mem[{work_loc[i], pick}]));
          // strict compare keeps ties on the lowest index
          if (i == 0 || t < best_t) begin
            best_t = t;
            best = i;
          end
        end
        res.finish = sat_sum(best_t, READY_W'(dist_mem[{pick, goal}]));
        res.agent = AGENT_W'(best);
        work_rdy[best] = res.finish;
        work_loc[best] = goal;
      end
    endcase
    for (int i = 0; i < n; i++)
      if (work_rdy[i] > res.span) res.span = work_rdy[i];
    return res;
  endfunction

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_TDATA_W-1:0] expected,
                                 input logic [OUT_TDATA_W-1:0] got);
    if (mismatches < PRINT_CAP)
      $display("mismatch at cycle %0d: %s expected %0h got %0h", cycle_count, what,
               expected, got);
    mismatches++;
  endtask

  // result sink with random back-pressure
  initial begin : sink_ready
    int g;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      g = idle_gap();
      if (g == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    sched_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, out_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[OUT_AGENT_LSB +: AGENT_W] !== exp_r.agent)
          report_mismatch("chosen_agent", exp_r.agent, out_tdata[OUT_AGENT_LSB +: AGENT_W]);
        if (out_tdata[OUT_FIN_LSB +: READY_W] !== exp_r.finish)
          report_mismatch("ready_time", exp_r.finish, out_tdata[OUT_FIN_LSB +: READY_W]);
        if (out_tdata[OUT_SPAN_LSB +: READY_W] !== exp_r.span)
          report_mismatch("makespan", exp_r.span, out_tdata[OUT_SPAN_LSB +: READY_W]);
      end
    end
  end

  function automatic item_data_t noise_item();
    item_data_t d;
    d = {$urandom, $urandom, $urandom};
    d[IN_TDATA_W-1:IN_USED_W] = '0;
    return d;
  endfunction

  function automatic item_data_t dist_item(logic [LOC_W-1:0] from, logic [LOC_W-1:0] to,
                                           logic [DIST_W-1:0] val);
    item_data_t d;
    d = noise_item();
    d[IN_FROM_LSB +: LOC_W]  = from;
    d[IN_TO_LSB +: LOC_W]    = to;
    d[IN_DVAL_LSB +: DIST_W] = val;
    return d;
  endfunction

  function automatic item_data_t start_item(logic [AGENT_W-1:0] idx, logic [LOC_W-1:0] loc,
                                            logic [READY_W-1:0] rdy);
    item_data_t d;
    d = noise_item();
    d[IN_AIDX_LSB +: AGENT_W] = idx;
    d[IN_ALOC_LSB +: LOC_W]   = loc;
    d[IN_ARDY_LSB +: READY_W] = rdy;
    return d;
  endfunction

  function automatic item_data_t task_item(logic [LOC_W-1:0] pick, logic [LOC_W-1:0] goal);
    item_data_t d;
    d = noise_item();
    d[IN_PICK_LSB +: LOC_W] = pick;
    d[IN_GOAL_LSB +: LOC_W] = goal;
    return d;
  endfunction

  function automatic logic [LOC_W-1:0] rand_site();
    return sites[$urandom_range(0, NUM_SITES - 1)];
  endfunction

  function automatic logic [DIST_W-1:0] rand_dist();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return DIST_W'($urandom_range(0, 15));
    if (r < 85) return DIST_W'($urandom);
    if (r < 95) return '1;
    return '0;
  endfunction

  function automatic logic [READY_W-1:0] rand_ready();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 1000);
    if (r < 70) return $urandom;
    if (r < 90) return 32'hFFFF_FFFF - $urandom_range(0, 70000);
    return '1;
  endfunction

  task automatic send_item(input gtaa_action_t act, input item_data_t d);
    int            gap;
    sched_result_t exp_item;
    gap = idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= act;
    in_tdata  <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    exp_item = schedule_step(act, d);
    pending_results.insert(pending_results.size(), exp_item);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_agent_count(input logic [COUNT_W-1:0] value);
    wait_drained();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    agent_count_reg = value;
  endtask

  task automatic test_distance_loads();
    write_agent_count(5'd2);
    send_item(ACT_DIST, dist_item('0, '0, '0));
    send_item(ACT_DIST, dist_item('0, '1, '1));
    send_item(ACT_DIST, dist_item('1, '0, 16'd1));
    send_item(ACT_DIST, dist_item('1, '1, 16'h1234));
  endtask

  task automatic test_basic_assign();
    // both agents idle at the same spot: tie on the lowest index
    send_item(ACT_ASSIGN, task_item('0, '1));
    send_item(ACT_ASSIGN, task_item('0, '0));
    send_item(ACT_ASSIGN, task_item('1, '0));
  endtask

  task automatic test_start_restart_saturation();
    send_item(ACT_START, start_item(4'd0, '1, '1));
    send_item(ACT_START, start_item(4'd1, '1, 32'hFFFF_FFF0));
    send_item(ACT_START, start_item(4'd15, '0, '0));
    // start writes leave the working agents alone until a restart
    send_item(ACT_ASSIGN, task_item('0, '0));
    send_item(ACT_RESTART, noise_item());
    // both agents clamp at the top of the time range
    send_item(ACT_ASSIGN, task_item('1, '1));
    send_item(ACT_ASSIGN, task_item('1, '0));
  endtask

  task automatic test_agent_count_limits();
    write_agent_count(5'd0);
    send_item(ACT_ASSIGN, task_item('0, '1));
    write_agent_count(5'd31);
    send_item(ACT_RESTART, noise_item());
    send_item(ACT_ASSIGN, task_item('1, '0));
    write_agent_count(5'd17);
    send_item(ACT_ASSIGN, task_item('0, '0));
    write_agent_count(5'd16);
    send_item(ACT_ASSIGN, task_item('0, '1));
  endtask

  task automatic test_random_schedules();
    int base;
    int phase;
    int m;
    int r;
    logic [COUNT_W-1:0] cnt;
    sites[0] = '0;
    sites[1] = '1;
    for (int i = 2; i < NUM_SITES; i++) sites[i] = LOC_W'($urandom_range(0, 255));
    base = items_sent;
    for (int i = 0; i < NUM_SITES; i++)
      for (int j = 0; j < NUM_SITES; j++)
        send_item(ACT_DIST, dist_item(sites[i], sites[j], rand_dist()));
    phase = 0;
    while (items_sent - base < RANDOM_ITEMS) begin
      case (phase)
        0:       cnt = 5'd16;
        1:       cnt = 5'd1;
        2:       cnt = 5'd0;
        3:       cnt = 5'd31;
        default: cnt = COUNT_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                            : $urandom_range(1, 16));
      endcase
      write_agent_count(cnt);
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(0, 5))
        send_item(ACT_START, start_item(AGENT_W'($urandom_range(0, 15)), rand_site(),
                                        rand_ready()));
      if ($urandom_range(0, 5) != 0) send_item(ACT_RESTART, noise_item());
      m = $urandom_range(8, 30);
      repeat (m) begin
        r = $urandom_range(0, 99);
        if (r < 78)
          send_item(ACT_ASSIGN, task_item(rand_site(), rand_site()));
        else if (r < 86)
          send_item(ACT_DIST, noise_item());
        else if (r < 92)
          send_item(ACT_DIST, dist_item(rand_site(), rand_site(), rand_dist()));
        else if (r < 97)
          send_item(ACT_START, start_item(AGENT_W'($urandom_range(0, 15)), rand_site(),
                                          rand_ready()));
        else
          send_item(ACT_RESTART, noise_item());
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tuser  = '0;
    in_tdata  = '0;
    in_tvalid = 1'b0;
    cfg_data  = '0;
    cfg_valid = 1'b0;
    calm      = 1'b0;
    mismatches  = 0;
    items_sent  = 0;
    cycle_count = 0;
    agent_count_reg = 5'd1;
    for (int i = 0; i < NUM_AGENTS; i++) begin
      start_loc[i] = '0;
      start_rdy[i] = '0;
      work_loc[i]  = '0;
      work_rdy[i]  = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_distance_loads();
    test_basic_assign();
    test_start_restart_saturation();
    test_agent_count_limits();
    test_random_schedules();
    wait_drained();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/gtaa_pkg.sv
rtl/gtaa_dist_ram.sv
rtl/gtaa_sat_alu.sv
rtl/greedy_task_agent_assignment_core.sv
tb/greedy_task_agent_assignment_core_tb.sv
